/* rtl/alm_pkg.sv */
`default_nettype none

package alm_pkg;

    localparam int ALPHA_W   = 8;
    localparam int EDGE_W    = 8;
    localparam int CFG_W     = 12;
    localparam int ROW_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_LINE_WIDTH = 2048;
    localparam int DEF_COL_W          = 11;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam int               MIN_DIM          = 3;

    localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

    // Output queue depth: one slot for the stencil stage, one for a stalled
    // result, one to keep the input open at full rate.
    localparam int OFIFO_DEPTH = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/alm_if.sv */
`default_nettype none

interface alm_in_if import alm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ALPHA_W-1:0] alpha_in;

    modport source (output valid, output alpha_in, input ready);
    modport sink   (input valid, input alpha_in, output ready);
endinterface

interface alm_out_if import alm_pkg::*; #(parameter int COL_W = DEF_COL_W) ();
    logic              valid;
    logic              ready;
    logic [EDGE_W-1:0] edge_value;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              frame_last;

    modport source (output valid, output edge_value, output out_col, output out_row,
                    output frame_last, input ready);
    modport sink   (input valid, input edge_value, input out_col, input out_row,
                    input frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/alm_ram.sv */
`default_nettype none

module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/alm_ofifo.sv */
`default_nettype none

module alm_ofifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop_ready,
    output logic                            head_valid,
    output logic      [WIDTH-1:0]           head_data,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign pop        = head_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNT_W'(DEPTH) || pop))
        else $error("result pushed into a full output queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("output queue count lost a push");

endmodule

`default_nettype wire

/* rtl/alpha_laplacian_edge_mask.sv */
// Alpha edge mask: four-neighbour Laplacian over a raster stream of alpha bytes.
//
// pix_ch carries one alpha byte per request in raster order; edge_ch returns one
// result per interior pixel (255 where up + down + left + right != 4 * centre,
// else 0) with zero-based interior column/row and a mark on the frame's last one.
// Border pixels produce nothing. The result for interior pixel (r, c) is produced
// by the request of pixel (r + 1, c + 1).
// The cfg port (cfg_we, cfg_index, cfg_data) sets frame_width (index 0) and
// frame_height (index 1); a write to either restarts the frame at row 0, column 0.
// Write it only while the block is idle.
// Throughput: one pixel per cycle while pix_ch.ready is high. A request is registered
// together with the registered read of the two line RAMs; the stencil add and compare
// then feed a three-entry queue, whose head drives edge_ch.
// When the receiver stalls the queue absorbs up to three results; pix_ch.ready
// drops once the queue plus the stencil stage would fill it, and rises again as
// soon as results are taken. Reset restores 640 x 480, clears counters, window
// and queue; line RAM contents need no clearing since every entry is written
// before a result uses it.
`default_nettype none

module alpha_laplacian_edge_mask import alm_pkg::*; #(
    parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    alm_in_if.sink                    pix_ch,
    alm_out_if.source                 edge_ch
);

    localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
    localparam int EW     = ($clog2(MAX_LINE_WIDTH + 1) > CFG_W) ?
                            $clog2(MAX_LINE_WIDTH + 1) : CFG_W;
    localparam int RES_W  = EDGE_W + DEF_COL_W + ROW_W + 1;
    localparam int QCNT_W = $clog2(OFIFO_DEPTH + 1);
    localparam int SUM_W  = ALPHA_W + 2;
    localparam logic [EW-1:0]    MAX_W = EW'(MAX_LINE_WIDTH);
    localparam logic [EW-1:0]    MIN_W = EW'(MIN_DIM);
    localparam logic [ROW_W-1:0] MIN_H = ROW_W'(MIN_DIM);

    // Configuration
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_hit;

    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            REG_FRAME_WIDTH:  cfg_hit = cfg_we;
            REG_FRAME_HEIGHT: cfg_hit = cfg_we;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective geometry: width clamped to [3, MAX_LINE_WIDTH], height at least 3
    logic [EW-1:0]    fw_ext;
    logic [EW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;

    assign fw_ext = EW'(frame_width_reg);
    assign eff_w  = (fw_ext < MIN_W) ? MIN_W : ((fw_ext > MAX_W) ? MAX_W : fw_ext);
    assign eff_h  = (frame_height_reg < MIN_H) ? MIN_H : frame_height_reg;

    // Position counters and request stage
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             last_col, last_row;
    logic             accept;
    logic             in_ready;
    logic [QCNT_W-1:0] q_count;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [DEF_COL_W-1:0] s1_ocol_reg;
    logic [ROW_W-1:0] s1_orow_reg;
    logic [ALPHA_W-1:0] s1_pix_reg;

    // Reserve a queue slot for the item in the stencil stage as well
    assign in_ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_reg))
                      < (QCNT_W + 1)'(OFIFO_DEPTH);
    assign pix_ch.ready = in_ready;
    assign accept = pix_ch.valid && in_ready;

    assign last_col = (EW'(col_reg) == eff_w - EW'(1));
    assign last_row = (row_reg == eff_h - ROW_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col_reg;
            s1_ocol_reg <= DEF_COL_W'(col_reg - COL_W'(2));
            s1_orow_reg <= row_reg - ROW_W'(2);
            s1_last_reg <= last_col && last_row;
            s1_pix_reg  <= pix_ch.alpha_in;
        end
    end

    // Line RAMs: read at request, write back in the following cycle at the same column
    logic [ALPHA_W-1:0] up_rd;
    logic [ALPHA_W-1:0] mid_rd;

    alm_ram #(
        .WIDTH (ALPHA_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_rd)
    );

    alm_ram #(
        .WIDTH (ALPHA_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_middle (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // Window: left/centre from the middle line, up and down taps one column back
    logic [ALPHA_W-1:0] win_left_reg;
    logic [ALPHA_W-1:0] win_ctr_reg;
    logic [ALPHA_W-1:0] win_up_reg;
    logic [ALPHA_W-1:0] win_down_reg;
    logic [SUM_W-1:0]   nb_sum;
    logic [SUM_W-1:0]   ctr_x4;
    logic [EDGE_W-1:0]  edge_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg <= '0;
            win_ctr_reg  <= '0;
            win_up_reg   <= '0;
            win_down_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_left_reg <= win_ctr_reg;
            win_ctr_reg  <= mid_rd;
            win_up_reg   <= up_rd;
            win_down_reg <= s1_pix_reg;
        end
    end

    assign nb_sum   = SUM_W'(win_left_reg) + SUM_W'(mid_rd)
                    + SUM_W'(win_up_reg) + SUM_W'(win_down_reg);
    assign ctr_x4   = {win_ctr_reg, 2'b00};
    assign edge_val = (nb_sum != ctr_x4) ? EDGE_ON : EDGE_OFF;

    // Output queue
    logic [RES_W-1:0] res_data;
    logic [RES_W-1:0] head_data;

    assign res_data = {edge_val, s1_ocol_reg, s1_orow_reg, s1_last_reg};

    alm_ofifo #(
        .WIDTH (RES_W),
        .DEPTH (OFIFO_DEPTH)
    ) u_ofifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_valid_reg && s1_emit_reg),
        .push_data  (res_data),
        .pop_ready  (edge_ch.ready),
        .head_valid (edge_ch.valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    assign {edge_ch.edge_value, edge_ch.out_col, edge_ch.out_row, edge_ch.frame_last}
        = head_data;

    a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (col_reg != s1_col_reg))
        else $error("line RAM read and write-back hit the same column");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |-> (EW'(col_reg) < eff_w))
        else $error("column counter beyond effective width");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col && last_row && !cfg_hit) |=> (col_reg == '0 && row_reg == '0))
        else $error("position did not wrap after the last pixel of the frame");

endmodule

`default_nettype wire
